/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert an implication on clk, quiet during reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Assert a condition that holds in every cycle out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`endif

/* hdl/lpg_pkg.sv */
// ----------------------------------------------------------------------------
// lpg_pkg
// Shared types and constants for the line prefix grouper.
// ----------------------------------------------------------------------------
package lpg_pkg;

    localparam int BUF_DEPTH = 15;

    localparam logic [1:0] ST_OPEN = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [11:0] LIMIT_RESET = 12'd16;

    // Item passed from the front (line assembly) to the back (grouping).
    typedef struct packed {
        logic [BUF_DEPTH-1:0][7:0] bytes;
        logic [3:0]                length;
        logic [31:0]               line_no;
    } line_t;

endpackage

/* hdl/line_prefix_grouper_core.sv */
// ----------------------------------------------------------------------------
// line_prefix_grouper_core
// Groups a byte stream of lines by shared prefix and reports each line.
// ----------------------------------------------------------------------------
//  channel | handshake          | carries
//  in      | in_valid/in_stall  | data_byte, end_of_line
//  out     | valid/stall        | status, group_index ... prefix_high
//  cfg     | cfg_valid/cfg_ready| group_limit (12 bits)
//
// One item per cycle while in_stall is low; an end-of-line item passes the
// queue and output register. The 15-byte compare sits in the back stage.
// rst_n clears all but the queue and report data; group_limit returns to 16.
// A stalled output backs up a two-entry queue, then stalls end-of-line items;
// data bytes keep flowing into the line buffer.
module line_prefix_grouper_core #(
    parameter int MAX_LINE_BYTES = 15,
    parameter int COUNT_BITS     = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        end_of_line,
    output logic        valid,
    input  logic        stall,
    output logic [1:0]  status,
    output logic [11:0] group_index,
    output logic [31:0] start_line,
    output logic [31:0] empty_lines,
    output logic [31:0] member_lines,
    output logic [3:0]  prefix_length,
    output logic [63:0] prefix_low,
    output logic [55:0] prefix_high,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [11:0] cfg_data
);
    logic [11:0]    limit_reg;
    logic           f_valid, f_stall, b_valid, b_stall;
    lpg_pkg::line_t f_item, b_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= lpg_pkg::LIMIT_RESET;
        else if (cfg_valid)
            limit_reg <= cfg_data;
    end

    lpg_front #(.MAX_LINE_BYTES(MAX_LINE_BYTES), .COUNT_BITS(COUNT_BITS)) u_front (
        .clk, .rst_n, .in_valid, .in_stall, .data_byte, .end_of_line,
        .line_valid(f_valid), .line_stall(f_stall), .line_item(f_item)
    );

    lpg_queue u_queue (
        .clk, .rst_n,
        .wr_valid(f_valid), .wr_stall(f_stall), .wr_item(f_item),
        .rd_valid(b_valid), .rd_stall(b_stall), .rd_item(b_item)
    );

    lpg_back #(.COUNT_BITS(COUNT_BITS)) u_back (
        .clk, .rst_n, .group_limit(limit_reg),
        .line_valid(b_valid), .line_stall(b_stall), .line_item(b_item),
        .valid, .stall, .status, .group_index, .start_line, .empty_lines,
        .member_lines, .prefix_length, .prefix_low, .prefix_high
    );

endmodule

/* hdl/lpg_front.sv */
// ----------------------------------------------------------------------------
// lpg_front
// Collects line bytes and hands each finished line to the queue.
// ----------------------------------------------------------------------------
module lpg_front #(
    parameter int MAX_LINE_BYTES = 15,
    parameter int COUNT_BITS     = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [7:0]    data_byte,
    input  logic          end_of_line,
    output logic          line_valid,
    input  logic          line_stall,
    output lpg_pkg::line_t line_item
);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic [lpg_pkg::BUF_DEPTH-1:0][7:0] buf_reg;
    logic [3:0]                         len_reg;
    logic [COUNT_BITS-1:0]              line_no_reg;
    logic                               accept;

    assign in_stall   = end_of_line && line_stall;
    assign accept     = in_valid && !in_stall;
    assign line_valid = in_valid && end_of_line;

    always_comb
    begin
        line_item.bytes   = buf_reg;
        line_item.length  = len_reg;
        line_item.line_no = 32'(line_no_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg     <= '0;
            len_reg     <= '0;
            line_no_reg <= '0;
        end
        else if (accept)
        begin
            if (end_of_line)
            begin
                buf_reg <= '0;
                len_reg <= '0;
                if (line_no_reg != CNT_MAX)
                    line_no_reg <= line_no_reg + 1'b1;
            end
            else if (data_byte != 8'd0 && 32'(len_reg) < MAX_LINE_BYTES)
            begin
                buf_reg[len_reg] <= data_byte;
                len_reg          <= len_reg + 4'd1;
            end
        end
    end

endmodule

/* hdl/lpg_queue.sv */
// ----------------------------------------------------------------------------
// lpg_queue
// Two-entry queue between line assembly and grouping.
// ----------------------------------------------------------------------------
module lpg_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_valid,
    output logic           wr_stall,
    input  lpg_pkg::line_t wr_item,
    output logic           rd_valid,
    input  logic           rd_stall,
    output lpg_pkg::line_t rd_item
);
`include "assert_macros.svh"

    lpg_pkg::line_t mem_reg [2];
    logic           wp_reg, rp_reg;
    logic [1:0]     cnt_reg;
    logic           push, pop;

    assign wr_stall = cnt_reg == 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_item  = mem_reg[rp_reg];
    assign push     = wr_valid && !wr_stall;
    assign pop      = rd_valid && !rd_stall;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wr_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= !wp_reg;
            if (pop)  rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    `ASSERT_ALWAYS(a_cnt_range, cnt_reg != 2'd3, "queue count out of range")
    `ASSERT_IMPL(a_cnt_ptr, cnt_reg == 2'd0 || cnt_reg == 2'd2, wp_reg == rp_reg,
        "queue pointers disagree with count")
    `ASSERT_IMPL(a_one_ptr, cnt_reg == 2'd1, wp_reg != rp_reg,
        "queue pointers equal with one item held")

endmodule

/* hdl/lpg_back.sv */
// ----------------------------------------------------------------------------
// lpg_back
// Classifies each line against the open group and registers the report.
// ----------------------------------------------------------------------------
module lpg_back #(
    parameter int COUNT_BITS = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [11:0]    group_limit,
    input  logic           line_valid,
    output logic           line_stall,
    input  lpg_pkg::line_t line_item,
    output logic           valid,
    input  logic           stall,
    output logic [1:0]     status,
    output logic [11:0]    group_index,
    output logic [31:0]    start_line,
    output logic [31:0]    empty_lines,
    output logic [31:0]    member_lines,
    output logic [3:0]     prefix_length,
    output logic [63:0]    prefix_low,
    output logic [55:0]    prefix_high
);
`include "assert_macros.svh"

    localparam int D = lpg_pkg::BUF_DEPTH;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic [D-1:0][7:0]     pre_reg, pre_next;
    logic [3:0]            plen_reg, plen_next;
    logic [31:0]           start_reg, start_next;
    logic [COUNT_BITS-1:0] empty_reg, empty_next, member_reg, member_next;
    logic [11:0]           done_reg, done_next;

    logic                  out_valid_reg;
    logic [1:0]            status_reg, status_next;
    logic [11:0]           gidx_reg, gidx_next;
    logic [31:0]           ostart_reg, ostart_next, oempty_reg, oempty_next;
    logic [31:0]           omember_reg, omember_next;
    logic [3:0]            oplen_reg, oplen_next;
    logic [D-1:0][7:0]     opre_reg, opre_next;

    logic                  take;
    logic [D-1:0]          match;
    logic [3:0]            common;
    logic                  nonempty;

    assign line_stall = out_valid_reg && stall;
    assign take       = line_valid && !line_stall;
    assign nonempty   = line_item.length != 4'd0;

    // Leading run of matching bytes, bounded by both lengths.
    always_comb
    begin
        common = '0;
        for (int i = 0; i < D; i++)
            match[i] = (pre_reg[i] == line_item.bytes[i]) && (4'(i) < plen_reg)
                       && (4'(i) < line_item.length);
        for (int i = D - 1; i >= 0; i--)
            if (!match[i]) common = 4'(i);
        if (&match) common = 4'(D);
    end

    always_comb
    begin
        pre_next     = pre_reg;
        plen_next    = plen_reg;
        start_next   = start_reg;
        empty_next   = empty_reg;
        member_next  = member_reg;
        done_next    = done_reg;
        status_next  = lpg_pkg::ST_OPEN;
        gidx_next    = done_reg;
        ostart_next  = start_reg;
        oempty_next  = 32'(empty_reg);
        omember_next = 32'(member_reg);
        oplen_next   = plen_reg;
        opre_next    = pre_reg;
        priority if (done_reg >= group_limit)
        begin
            status_next  = lpg_pkg::ST_FULL;
            gidx_next    = '0;
            ostart_next  = '0;
            oempty_next  = '0;
            omember_next = '0;
            oplen_next   = '0;
            opre_next    = '0;
        end
        else if (plen_reg != 4'd0)
        begin
            if (nonempty && common != 4'd0)
            begin
                for (int i = 0; i < D; i++)
                    if (4'(i) >= common) pre_next[i] = 8'd0;
                plen_next = common;
                if (member_reg != CNT_MAX) member_next = member_reg + 1'b1;
                oplen_next   = common;
                opre_next    = pre_next;
                omember_next = 32'(member_next);
            end
            else
            begin
                status_next = lpg_pkg::ST_DONE;
                done_next   = done_reg + 12'd1;
                pre_next    = '0;
                plen_next   = '0;
                start_next  = '0;
                empty_next  = '0;
                member_next = '0;
                if (done_next < group_limit)
                begin
                    if (nonempty)
                    begin
                        pre_next    = line_item.bytes;
                        plen_next   = line_item.length;
                        start_next  = line_item.line_no;
                        member_next = COUNT_BITS'(1);
                    end
                    else
                        empty_next = COUNT_BITS'(1);
                end
            end
        end
        else
        begin
            if (nonempty)
            begin
                pre_next    = line_item.bytes;
                plen_next   = line_item.length;
                start_next  = line_item.line_no;
                member_next = COUNT_BITS'(1);
            end
            else if (empty_reg != CNT_MAX)
                empty_next = empty_reg + 1'b1;
            ostart_next  = start_next;
            oempty_next  = 32'(empty_next);
            omember_next = 32'(member_next);
            oplen_next   = plen_next;
            opre_next    = pre_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_reg       <= '0;
            plen_reg      <= '0;
            start_reg     <= '0;
            empty_reg     <= '0;
            member_reg    <= '0;
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                pre_reg    <= pre_next;
                plen_reg   <= plen_next;
                start_reg  <= start_next;
                empty_reg  <= empty_next;
                member_reg <= member_next;
                done_reg   <= done_next;
                out_valid_reg <= 1'b1;
            end
            else if (!stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            status_reg  <= status_next;
            gidx_reg    <= gidx_next;
            ostart_reg  <= ostart_next;
            oempty_reg  <= oempty_next;
            omember_reg <= omember_next;
            oplen_reg   <= oplen_next;
            opre_reg    <= opre_next;
        end
    end

    assign valid         = out_valid_reg;
    assign status        = status_reg;
    assign group_index   = gidx_reg;
    assign start_line    = ostart_reg;
    assign empty_lines   = oempty_reg;
    assign member_lines  = omember_reg;
    assign prefix_length = oplen_reg;
    assign prefix_low    = opre_reg[7:0];
    assign prefix_high   = opre_reg[14:8];

    `ASSERT_IMPL(a_group_shape, plen_reg != 4'd0, member_reg != '0,
        "open prefix without members")
    `ASSERT_IMPL(a_done_step, take, done_next == done_reg || done_next == done_reg + 12'd1,
        "completed count jumped")
    `ASSERT_IMPL(a_full_zero, valid && status == lpg_pkg::ST_FULL, prefix_length == 4'd0,
        "full report carries a prefix")

endmodule
